// File: hdl/range_binned_histogram_assert.svh
// Assertion macros used by the checker in hdl/rbh_checker.sv.
`ifndef RANGE_BINNED_HISTOGRAM_ASSERT_SVH
`define RANGE_BINNED_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RBH_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbh assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RBH_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbh assertion failed");

`endif

// File: hdl/rbh_pkg.sv
package rbh_pkg;

  // Command codes of an input item; code 3 is unused, changes no state and yields a result with the reject total only.
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_LOWER = 2'd0,
    REG_UPPER = 2'd1,
    REG_SCALE = 2'd2,
    REG_BINS  = 2'd3
  } rbh_reg_e;

  localparam int SAMPLE_WIDTH = 16;

  localparam int CMD_W   = 2;
  localparam int BOUND_W = 16;
  localparam int SCALE_W = 24;
  localparam int FRAC_W  = 16;
  localparam int BINS_W  = 7;
  localparam int SEL_W   = 6;
  localparam int OUT_W   = 32;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [BOUND_W-1:0] lower;
    logic [BOUND_W-1:0] upper;
    logic [SCALE_W-1:0] scale;
    logic [BINS_W-1:0]  bins_used;
  } rbh_cfg_t;

  // Decoded operation handed from the classifier to the count store.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             hit;
    logic             rd_ok;
    logic [SEL_W-1:0] bin_index;
  } rbh_op_t;

endpackage

// File: hdl/rbh_in_if.sv
interface rbh_in_if ();
  import rbh_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [CMD_W-1:0]               cmd;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           sample_is_nan;
  logic [SEL_W-1:0]               bin_select;

  modport source (output valid, cmd, sample, sample_is_nan, bin_select, input ready);
  modport sink   (input valid, cmd, sample, sample_is_nan, bin_select, output ready);
endinterface

// File: hdl/rbh_out_if.sv
interface rbh_out_if ();
  import rbh_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] bin_index;
  logic             classified;
  logic [OUT_W-1:0] bin_value;
  logic [OUT_W-1:0] reject_total;

  modport source (output valid, bin_index, classified, bin_value, reject_total, input ready);
  modport sink   (input valid, bin_index, classified, bin_value, reject_total, output ready);
endinterface

// File: hdl/range_binned_histogram.sv
// Uniform-bin histogram with saturating bin counts and reject counter.
// Each item passes the input, offset, product, update and result registers.
// Throughput: one item per cycle while the result side is not stalled; the bin read-modify-write forwards the
// previous cycle's write, so back-to-back hits on one bin run at full rate.
// Reset (async, active low) zeroes all counts through per-bin valid bits,
// clears the reject counter and loads the register defaults; no clearing pass.
module range_binned_histogram #(
  parameter int NUM_BINS     = 64,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  rbh_in_if.sink      in_i,
  rbh_out_if.source   out_o
);
  import rbh_pkg::*;

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // Configuration registers
  rbh_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower     <= BOUND_W'(0);
      cfg_q.upper     <= BOUND_W'(32767);
      cfg_q.scale     <= SCALE_W'(128);
      cfg_q.bins_used <= BINS_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOWER: cfg_q.lower     <= cfg_data_i[BOUND_W-1:0];
        REG_UPPER: cfg_q.upper     <= cfg_data_i[BOUND_W-1:0];
        REG_SCALE: cfg_q.scale     <= cfg_data_i[SCALE_W-1:0];
        REG_BINS:  cfg_q.bins_used <= cfg_data_i[BINS_W-1:0];
        default:   cfg_q           <= cfg_q;
      endcase
    end
  end

  logic          cls_valid, store_adv;
  rbh_op_t       cls_op;
  logic [AW-1:0] cls_addr;

  rbh_classify #(
    .NUM_BINS    (NUM_BINS),
    .AW          (AW)
  ) u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .adv_i  (store_adv),
    .valid_o(cls_valid),
    .op_o   (cls_op),
    .addr_o (cls_addr)
  );

  rbh_store #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_WIDTH(COUNT_WIDTH),
    .AW         (AW)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(cls_valid),
    .op_i   (cls_op),
    .addr_i (cls_addr),
    .adv_o  (store_adv),
    .out_o  (out_o)
  );

endmodule

// File: hdl/rbh_classify.sv
module rbh_classify #(
  parameter int NUM_BINS     = 64,
  parameter int AW           = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbh_pkg::rbh_cfg_t cfg_i,
  rbh_in_if.sink            in_i,
  input  logic              adv_i,
  output logic              valid_o,
  output rbh_pkg::rbh_op_t  op_o,
  output logic [AW-1:0]     addr_o
);
  import rbh_pkg::*;

  localparam int CW = ((SAMPLE_WIDTH > BOUND_W) ? SAMPLE_WIDTH : BOUND_W) + 1;
  localparam int PW = CW + SCALE_W;
  localparam int BW = PW - FRAC_W;

  // Stage valids and flow control
  logic v1_q, v2_q, v3_q;
  logic free1, free2, free3;

  assign free3      = !v3_q || adv_i;
  assign free2      = !v2_q || free3;
  assign free1      = !v1_q || free2;
  assign in_i.ready = free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (free1) v1_q <= in_i.valid;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
    end
  end

  // Stage 1: input register
  logic [CMD_W-1:0]               cmd1_q;
  logic signed [SAMPLE_WIDTH-1:0] sample1_q;
  logic                           nan1_q;
  logic [SEL_W-1:0]               sel1_q;

  always_ff @(posedge clk_i) begin
    if (free1) begin
      cmd1_q    <= in_i.cmd;
      sample1_q <= in_i.sample;
      nan1_q    <= in_i.sample_is_nan;
      sel1_q    <= in_i.bin_select;
    end
  end

  // Bound checks and offset from the lower bound
  logic signed [CW-1:0] s_ext, lo_ext, hi_ext, diff;
  logic                 rng_d;

  always_comb begin
    s_ext  = CW'(sample1_q);
    lo_ext = CW'($signed(cfg_i.lower));
    hi_ext = CW'($signed(cfg_i.upper));
    diff   = s_ext - lo_ext;
    rng_d  = !nan1_q && (s_ext >= lo_ext) && (s_ext <= hi_ext);
  end

  // Stage 2: offset register
  logic [CMD_W-1:0] cmd2_q;
  logic [SEL_W-1:0] sel2_q;
  logic             rng2_q;
  logic [CW-1:0]    diff2_q;

  always_ff @(posedge clk_i) begin
    if (free2) begin
      cmd2_q  <= cmd1_q;
      sel2_q  <= sel1_q;
      rng2_q  <= rng_d;
      diff2_q <= diff;
    end
  end

  // Scale the offset: Q8.16 bins per unit
  logic [PW-1:0] prod_d;
  assign prod_d = PW'(diff2_q) * PW'(cfg_i.scale);

  // Stage 3: product register
  logic [CMD_W-1:0] cmd3_q;
  logic [SEL_W-1:0] sel3_q;
  logic             rng3_q;
  logic [PW-1:0]    prod3_q;

  always_ff @(posedge clk_i) begin
    if (free3) begin
      cmd3_q  <= cmd2_q;
      sel3_q  <= sel2_q;
      rng3_q  <= rng2_q;
      prod3_q <= prod_d;
    end
  end

  // Bin number, limit check and store address
  logic [BW-1:0] bin;
  logic          hit;
  logic          is_add, is_read;

  always_comb begin
    bin     = prod3_q[PW-1:FRAC_W];
    hit     = rng3_q && (bin < BW'(cfg_i.bins_used)) && (bin < BW'(NUM_BINS));
    is_add  = (cmd3_q == CMD_ADD);
    is_read = (cmd3_q == CMD_READ);

    op_o.cmd       = cmd3_q;
    op_o.hit       = is_add && hit;
    op_o.rd_ok     = is_read && (BW'(sel3_q) < BW'(NUM_BINS));
    op_o.bin_index = '0;
    if (is_add && hit) begin
      op_o.bin_index = bin[SEL_W-1:0];
    end else if (is_read) begin
      op_o.bin_index = sel3_q;
    end
    addr_o = is_add ? AW'(bin) : AW'(sel3_q);
  end

  assign valid_o = v3_q;

endmodule

// File: hdl/rbh_store.sv
module rbh_store #(
  parameter int NUM_BINS    = 64,
  parameter int COUNT_WIDTH = 32,
  parameter int AW          = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rbh_pkg::rbh_op_t op_i,
  input  logic [AW-1:0]    addr_i,
  output logic             adv_o,
  rbh_out_if.source        out_o
);
  import rbh_pkg::*;

  // Flow control for the update stage and the result register
  logic    v4_q, out_v_q;
  logic    free4, free5, fire4;
  rbh_op_t op4_q;
  logic [AW-1:0] addr4_q;

  assign free5 = !out_v_q || out_o.ready;
  assign free4 = !v4_q || free5;
  assign fire4 = v4_q && free5;
  assign adv_o = free4;

  // Count memory, read registered on the way into the update stage
  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic                   wr_en;

  assign wr_en = fire4 && op4_q.hit;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[addr4_q] <= new_cnt;
    if (free4) rdata_q <= mem[addr_i];
  end

  // Entry valid bits: a cleared entry reads as zero
  logic [NUM_BINS-1:0] vld_q;
  logic                do_clear;

  assign do_clear = fire4 && (op4_q.cmd == CMD_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (do_clear) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr4_q] <= 1'b1;
    end
  end

  // Last write, forwarded to the item whose read went out in the same cycle
  logic                   lw_v_q;
  logic [AW-1:0]          lw_addr_q;
  logic [COUNT_WIDTH-1:0] lw_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q   <= 1'b0;
      lw_v_q <= 1'b0;
    end else if (free4) begin
      v4_q   <= valid_i;
      lw_v_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free4) begin
      op4_q     <= op_i;
      addr4_q   <= addr_i;
      lw_addr_q <= addr4_q;
      lw_data_q <= new_cnt;
    end
  end

  // Current count and saturating increment
  logic [COUNT_WIDTH-1:0] cur;

  always_comb begin
    if (lw_v_q && (lw_addr_q == addr4_q)) begin
      cur = lw_data_q;
    end else if (vld_q[addr4_q]) begin
      cur = rdata_q;
    end else begin
      cur = '0;
    end
    new_cnt = (&cur) ? cur : cur + COUNT_WIDTH'(1);
  end

  // Reject counter
  logic [COUNT_WIDTH-1:0] rej_q, rej_d;

  always_comb begin
    rej_d = rej_q;
    if (fire4) begin
      case (op4_q.cmd)
        CMD_ADD:   if (!op4_q.hit && !(&rej_q)) rej_d = rej_q + COUNT_WIDTH'(1);
        CMD_CLEAR: rej_d = '0;
        default:   rej_d = rej_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q <= '0;
    end else begin
      rej_q <= rej_d;
    end
  end

  // Result register
  logic [SEL_W-1:0] idx_q;
  logic             cls_q;
  logic [OUT_W-1:0] val_q, rtot_q;
  logic [OUT_W-1:0] val_d;

  always_comb begin
    val_d = '0;
    if (op4_q.hit) begin
      val_d = OUT_W'(new_cnt);
    end else if (op4_q.rd_ok) begin
      val_d = OUT_W'(cur);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (free5) begin
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire4) begin
      idx_q  <= op4_q.bin_index;
      cls_q  <= op4_q.hit;
      val_q  <= val_d;
      rtot_q <= OUT_W'(rej_d);
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.bin_index    = idx_q;
  assign out_o.classified   = cls_q;
  assign out_o.bin_value    = val_q;
  assign out_o.reject_total = rtot_q;

endmodule

// File: hdl/rbh_checker.sv
`include "range_binned_histogram_assert.svh"

module rbh_checker #(
  parameter int COUNT_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_classified_i,
  input logic [31:0] out_bin_value_i,
  input logic [31:0] out_reject_total_i
);

  // Reject total of the previous result
  logic        out_fire;
  logic        out_stall;
  logic [63:0] out_counts;
  logic        hit_ok;
  logic        rej_ok;
  logic        seen_q;
  logic [31:0] last_rej_q;

  assign out_fire   = out_valid_i && out_ready_i;
  assign out_stall  = out_valid_i && !out_ready_i;
  assign out_counts = {out_bin_value_i, out_reject_total_i};
  assign hit_ok     = (COUNT_WIDTH > 32) || (out_bin_value_i != 32'd0);
  assign rej_ok     = (out_reject_total_i == last_rej_q) ||
                      (out_reject_total_i == 32'(last_rej_q + 32'd1)) ||
                      (out_reject_total_i == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_rej_q <= '0;
    end else if (out_fire) begin
      seen_q     <= 1'b1;
      last_rej_q <= out_reject_total_i;
    end
  end

  // Input stalls only when a result is held back
  `RBH_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_i, out_stall)

  // A held result keeps its counts
  `RBH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_counts))

  // A counted sample leaves its bin nonzero
  `RBH_ASSERT_IMP(a_hit_nonzero, clk_i, rst_ni, out_valid_i && out_classified_i, hit_ok)

  // Reject total moves by at most one per result, or drops to zero on clear
  `RBH_ASSERT_IMP(a_reject_step, clk_i, rst_ni, out_fire && seen_q, rej_ok)

endmodule

bind range_binned_histogram rbh_checker #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_rbh_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_classified_i  (out_o.classified),
  .out_bin_value_i   (out_o.bin_value),
  .out_reject_total_i(out_o.reject_total)
);

// File: verif/rbh_tb_pkg.sv
package rbh_tb_pkg;

  // Spare command code: no state change, reports the reject total only
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Bins built into the block
  localparam int HIST_BINS = 64;

endpackage

// File: verif/rbh_checker.sv
module rbh_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  rbh_in_if           in_i,
  rbh_out_if          out_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          hits_o,
  output int          rejects_o,
  output int          reads_o,
  output int          clears_o
);
  import rbh_pkg::*;
  import rbh_tb_pkg::*;

  typedef struct packed {
    logic [SEL_W-1:0] bin_index;
    logic             classified;
    logic [OUT_W-1:0] bin_value;
    logic [OUT_W-1:0] reject_total;
  } tally_t;

  tally_t expected_tallies[$];

  // Shadow histogram and register copies
  logic [OUT_W-1:0]          hist_counts [HIST_BINS];
  logic [OUT_W-1:0]          reject_count;
  logic signed [BOUND_W-1:0] lower_q;
  logic signed [BOUND_W-1:0] upper_q;
  logic [SCALE_W-1:0]        scale_q;
  logic [BINS_W-1:0]         bins_q;

  function automatic logic [OUT_W-1:0] bump_saturating(input logic [OUT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Apply one item to the shadow histogram and queue the result it yields
  task automatic tally_item(input logic [1:0] cmd, input logic signed [BOUND_W-1:0] smp,
                            input logic nan, input logic [SEL_W-1:0] sel);
    tally_t     t;
    int         diff;
    int         bin_lim;
    logic [63:0] prod;
    logic       hit;
    logic [SEL_W-1:0] idx;
    t   = '0;
    hit = 1'b0;
    idx = '0;
    case (cmd)
      CMD_ADD: begin
        if (!nan && smp >= lower_q && smp <= upper_q) begin
          diff    = int'(smp) - int'(lower_q);
          prod    = (64'(diff) * 64'(scale_q)) >> FRAC_W;
          bin_lim = (bins_q < HIST_BINS) ? int'(bins_q) : HIST_BINS;
          hit     = prod < 64'(bin_lim);
          idx     = prod[SEL_W-1:0];
        end
        if (hit) begin
          hist_counts[idx] = bump_saturating(hist_counts[idx]);
          t.bin_index  = idx;
          t.classified = 1'b1;
          t.bin_value  = hist_counts[idx];
          hits_o++;
        end else begin
          reject_count = bump_saturating(reject_count);
          rejects_o++;
        end
      end
      CMD_READ: begin
        t.bin_index = sel;
        t.bin_value = hist_counts[sel];
        reads_o++;
      end
      CMD_CLEAR: begin
        foreach (hist_counts[i]) hist_counts[i] = '0;
        reject_count = '0;
        clears_o++;
      end
      default: ;
    endcase
    t.reject_total = reject_count;
    expected_tallies.push_back(t);
  endtask

  // Model update and result comparison on each clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    tally_t got;
    tally_t want;
    if (!rst_ni) begin
      foreach (hist_counts[i]) hist_counts[i] = '0;
      reject_count = '0;
      lower_q      = 16'sd0;
      upper_q      = 16'sd32767;
      scale_q      = 24'd128;
      bins_q       = 7'd64;
      expected_tallies.delete();
      mismatches_o = 0;
      pending_o    = 0;
      hits_o       = 0;
      rejects_o    = 0;
      reads_o      = 0;
      clears_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOWER: lower_q = cfg_data_i[BOUND_W-1:0];
          REG_UPPER: upper_q = cfg_data_i[BOUND_W-1:0];
          REG_SCALE: scale_q = cfg_data_i[SCALE_W-1:0];
          REG_BINS:  bins_q  = cfg_data_i[BINS_W-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready)
        tally_item(in_i.cmd, in_i.sample, in_i.sample_is_nan, in_i.bin_select);
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.bin_index, out_i.classified, out_i.bin_value, out_i.reject_total};
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result idx=%0d cls=%0b val=%0d rej=%0d", $time,
                   got.bin_index, got.classified, got.bin_value, got.reject_total);
          mismatches_o++;
        end else begin
          want = expected_tallies.pop_front();
          if (got !== want) begin
            $display("%0t: expected idx=%0d cls=%0b val=%0d rej=%0d", $time,
                     want.bin_index, want.classified, want.bin_value, want.reject_total);
            $display("%0t:   actual idx=%0d cls=%0b val=%0d rej=%0d", $time,
                     got.bin_index, got.classified, got.bin_value, got.reject_total);
            mismatches_o++;
          end
        end
      end
      pending_o = expected_tallies.size();
    end
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  import rbh_pkg::*;
  import rbh_tb_pkg::*;

  localparam int RESULT_LATENCY = 4;
  localparam int IDLE_LIMIT     = 2000;
  localparam int NUM_PHASES     = 11;
  localparam int PHASE_ITEMS    = 58;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;

  int mismatches, pending, hits, rejects, reads, clears;
  int burst_left;
  int items_sent;
  int idle_cycles;
  int cur_lo, cur_hi;
  bit calm_sender;

  rbh_in_if in_if ();
  rbh_out_if out_if ();

  range_binned_histogram u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  rbh_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_if),
    .out_i        (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .hits_o       (hits),
    .rejects_o    (rejects),
    .reads_o      (reads),
    .clears_o     (clears)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: ready follows a periodic stall pattern whose period and stall length are redrawn each random epoch
  initial begin
    int cyc, period, stall, epoch;
    out_if.ready = 1'b0;
    cyc   = 0;
    epoch = 0;
    forever begin
      @(negedge clk_i);
      if (epoch == 0) begin
        period = $urandom_range(2, 10);
        stall  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, period - 1);
        epoch  = $urandom_range(20, 80);
      end
      out_if.ready = (cyc % period) >= stall;
      cyc++;
      epoch--;
    end
  end

  // Watchdog: no item moving on either channel for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item in bursts with random gaps; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] smp,
                           input logic nan, input logic [5:0] sel);
    int gap;
    if (burst_left == 0) begin
      gap = calm_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.cmd           = cmd;
    in_if.sample        = smp;
    in_if.sample_is_nan = nan;
    in_if.bin_select    = sel;
    in_if.valid         = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input rbh_reg_e idx, input logic [23:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // Pick and load one register setting; the first few are corner settings
  task automatic apply_setting(input int p);
    int lo, hi, scl, nb, span, room;
    case (p)
      0: begin lo = -32768; hi = 32767; scl = 24'hFFFFFF; nb = 127; end
      1: begin lo = -32768; hi = 32767; scl = 64;         nb = 64;  end
      2: begin lo = 100;    hi = 50;    scl = 128;        nb = 64;  end
      3: begin lo = -2000;  hi = 2000;  scl = 0;          nb = 1;   end
      4: begin lo = -32768; hi = 32767; scl = 64;         nb = 0;   end
      5: begin lo = 32767;  hi = 32767; scl = 24'hFFFFFF; nb = 64;  end
      default: begin
        lo   = int'($urandom_range(0, 65535)) - 32768;
        room = 32767 - lo;
        span = $urandom_range(0, 1) ? $urandom_range(0, room)
                                    : $urandom_range(0, (room < 255) ? room : 255);
        hi   = lo + span;
        nb   = $urandom_range(1, 64);
        scl  = (nb * 65536) / (span + 1) + $urandom_range(0, 3);
        if (scl > 24'hFFFFFF) scl = 24'hFFFFFF;
        if ($urandom_range(0, 4) == 0) nb = $urandom_range(65, 127);
      end
    endcase
    cur_lo = lo;
    cur_hi = hi;
    // junk in the unused upper data bits must be ignored
    write_reg(REG_LOWER, {8'($urandom), 16'(lo)});
    write_reg(REG_UPPER, {8'($urandom), 16'(hi)});
    write_reg(REG_SCALE, 24'(scl));
    write_reg(REG_BINS,  {17'($urandom), 7'(nb)});
  endtask

  // Mostly adds inside the current bounds, some at the edges, some anywhere
  task automatic random_item();
    int pick, s;
    logic [1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 78)      cmd = CMD_ADD;
    else if (pick < 93) cmd = CMD_READ;
    else if (pick < 97) cmd = CMD_CLEAR;
    else                cmd = CMD_SPARE;
    pick = $urandom_range(0, 99);
    if (pick < 65 && cur_lo <= cur_hi)
      s = cur_lo + int'($urandom_range(0, cur_hi - cur_lo));
    else if (pick < 82) begin
      case ($urandom_range(0, 3))
        0: s = cur_lo - 1;
        1: s = cur_lo;
        2: s = cur_hi;
        default: s = cur_hi + 1;
      endcase
    end else
      s = $urandom_range(0, 65535);
    send_item(cmd, 16'(s), $urandom_range(0, 9) == 0, 6'($urandom));
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_LOWER;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_ADD;
    in_if.sample        = '0;
    in_if.sample_is_nan = 1'b0;
    in_if.bin_select    = '0;
    idle_cycles         = 0;
    burst_left          = 0;
    items_sent          = 0;
    calm_sender         = 1'b0;
    cur_lo              = 0;
    cur_hi              = 32767;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at the reset setting: 512 sample units per bin
    send_item(CMD_ADD,   16'sd0,      1'b0, 6'd0);   // lowest bin
    send_item(CMD_ADD,   16'sd511,    1'b0, 6'd0);   // same bin back to back
    send_item(CMD_ADD,   16'sd511,    1'b0, 6'd0);
    send_item(CMD_ADD,   16'sd512,    1'b0, 6'd0);   // next bin up
    send_item(CMD_ADD,   16'sd32767,  1'b0, 6'd0);   // top bin
    send_item(CMD_ADD,   16'sd32767,  1'b0, 6'd0);
    send_item(CMD_ADD,   -16'sd1,     1'b0, 6'd0);   // just below lower bound
    send_item(CMD_ADD,   -16'sd32768, 1'b0, 6'd63);  // most negative sample
    send_item(CMD_ADD,   16'sd100,    1'b1, 6'd0);   // NaN inside range
    send_item(CMD_READ,  16'sd0,      1'b0, 6'd0);
    send_item(CMD_READ,  -16'sd1,     1'b1, 6'd63);
    send_item(CMD_READ,  16'sd0,      1'b0, 6'd1);
    send_item(CMD_READ,  16'sd0,      1'b0, 6'd5);   // never hit
    send_item(CMD_SPARE, 16'sd200,    1'b0, 6'd7);   // spare code changes nothing
    send_item(CMD_CLEAR, 16'sd0,      1'b0, 6'd0);
    send_item(CMD_READ,  16'sd0,      1'b0, 6'd0);   // zero after clear
    send_item(CMD_ADD,   16'sd1000,   1'b0, 6'd0);

    // Random items over a series of register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_setting(p);
      calm_sender = (p % 4 == 1);
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (RESULT_LATENCY + 4) @(posedge clk_i);
    $display("Sent %0d items over %0d register settings: %0d hits, %0d rejects,",
             items_sent, NUM_PHASES + 1, hits, rejects);
    $display("%0d bin reads, %0d clears, with sender gaps and result-side stalls.",
             reads, clears);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
